[design/bb3_pkg.sv]
// Shared types, constants and arithmetic helpers of the 3x3 box blur unit.
package bb3_pkg;

    // Field widths
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int SUM_W  = 12;          // nine 8-bit values
    localparam int COL_W  = 12;          // column position, as wide as frame_width
    localparam int ROW_W  = 12;          // row position
    localparam int HGT_W  = 13;          // frame_height register
    localparam int OX_W   = 11;
    localparam int OY_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register geometry
    localparam logic [COL_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HGT_W-1:0] ROW_LIMIT    = 13'd4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Reciprocal of 9 in 16 fraction bits; exact for sums up to 9 * 255
    localparam logic [12:0] RECIP_9 = 13'd7282;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sum;

    // One pixel request on its way to the output stage
    typedef struct packed {
        t_sum             sum;
        t_pix             pix;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             has_int;
        logic             has_bord;
    } t_item;

    // Truncated s / 9 by multiply and shift
    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+12:0] p;
        p = {13'd0, s} * {12'd0, RECIP_9};
        return p[16 +: CHAN_W];
    endfunction

endpackage

[design/bb3_line_store.sv]
// Two-line store of the blur unit: one memory, both rows above side by side.
module bb3_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [2*bb3_pkg::PIX_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [2*bb3_pkg::PIX_W-1:0] i_wr_data
);

    logic [2*bb3_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*bb3_pkg::PIX_W-1:0] r_rd_data;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bb3_window.sv]
// Two previous window columns and the per-channel nine-pixel sums.
module bb3_window (
    input  logic          i_clk,
    input  logic          i_shift,
    input  bb3_pkg::t_pix i_top,
    input  bb3_pkg::t_pix i_mid,
    input  bb3_pkg::t_pix i_pix,
    output bb3_pkg::t_sum o_sum
);

    // Entries 0..2 previous column, 3..5 the one before; top, middle, current row
    bb3_pkg::t_pix r_win [6];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= i_top;
            r_win[1] <= i_mid;
            r_win[2] <= i_pix;
        end
    end

    // Nine-term sums, zero-extended per channel
    always_comb begin
        o_sum.red   = bb3_pkg::SUM_W'(i_top.red) + bb3_pkg::SUM_W'(i_mid.red)
                    + bb3_pkg::SUM_W'(i_pix.red);
        o_sum.green = bb3_pkg::SUM_W'(i_top.green) + bb3_pkg::SUM_W'(i_mid.green)
                    + bb3_pkg::SUM_W'(i_pix.green);
        o_sum.blue  = bb3_pkg::SUM_W'(i_top.blue) + bb3_pkg::SUM_W'(i_mid.blue)
                    + bb3_pkg::SUM_W'(i_pix.blue);
        for (int i = 0; i < 6; i++) begin
            o_sum.red   = o_sum.red   + bb3_pkg::SUM_W'(r_win[i].red);
            o_sum.green = o_sum.green + bb3_pkg::SUM_W'(r_win[i].green);
            o_sum.blue  = o_sum.blue  + bb3_pkg::SUM_W'(r_win[i].blue);
        end
    end

endmodule

[design/bb3_emit.sv]
// Divide stage and output register; sends zero, one or two results per request.
module bb3_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  bb3_pkg::t_item             i_item,
    output logic                       o_ready,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bb3_pkg::CHAN_W-1:0] o_out_red,
    output logic [bb3_pkg::CHAN_W-1:0] o_out_green,
    output logic [bb3_pkg::CHAN_W-1:0] o_out_blue,
    output logic [bb3_pkg::OX_W-1:0]   o_out_x,
    output logic [bb3_pkg::OY_W-1:0]   o_out_y,
    output logic                       o_run_last
);

    logic           r_s2v;
    bb3_pkg::t_item r_s2;
    logic           r_ov;
    bb3_pkg::t_pix  r_opix;
    logic [bb3_pkg::OX_W-1:0] r_ox;
    logic [bb3_pkg::OY_W-1:0] r_oy;
    logic           r_olast;

    logic           out_ready;
    logic           pend;
    logic           two;
    logic           emit_now;
    logic           s2_adv;
    logic           s2_ready;
    bb3_pkg::t_pix  n_opix;
    logic [bb3_pkg::COL_W-1:0] n_ox;
    logic [bb3_pkg::ROW_W-1:0] n_oy;
    logic           n_olast;

    // Handshake of the result slot and the stage in front of it
    assign out_ready = !r_ov || !i_stall;
    assign pend      = r_s2.has_int || r_s2.has_bord;
    assign two       = r_s2.has_int && r_s2.has_bord;
    assign emit_now  = r_s2v && pend && out_ready;
    assign s2_adv    = r_s2v && (!pend || (out_ready && !two));
    assign s2_ready  = !r_s2v || s2_adv;
    assign o_ready   = s2_ready;

    // Interior result first, then the border pixel
    always_comb begin
        if (r_s2.has_int) begin
            n_opix.red   = bb3_pkg::div9(r_s2.sum.red);
            n_opix.green = bb3_pkg::div9(r_s2.sum.green);
            n_opix.blue  = bb3_pkg::div9(r_s2.sum.blue);
            n_ox         = r_s2.x - 12'd1;
            n_oy         = r_s2.y - 12'd1;
            n_olast      = !r_s2.has_bord;
        end else begin
            n_opix       = r_s2.pix;
            n_ox         = r_s2.x;
            n_oy         = r_s2.y;
            n_olast      = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2v <= i_valid;
            end
            if (out_ready) begin
                r_ov <= emit_now;
            end
        end
    end

    // Payload; the interior flag drops once that result has gone out
    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_s2 <= i_item;
        end else if (emit_now) begin
            r_s2.has_int <= 1'b0;
        end
        if (emit_now) begin
            r_opix  <= n_opix;
            r_ox    <= n_ox[bb3_pkg::OX_W-1:0];
            r_oy    <= n_oy[bb3_pkg::OY_W-1:0];
            r_olast <= n_olast;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_red   = r_opix.red;
    assign o_out_green = r_opix.green;
    assign o_out_blue  = r_opix.blue;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_run_last  = r_olast;

    // A two-result request keeps only its border pixel after the first send
    a_two_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2v && two && out_ready) |=> (r_s2v && !r_s2.has_int && r_s2.has_bord))
        else $error("two-result request not split correctly");

    // A first-of-two result always has its partner waiting behind it
    a_partner_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_olast) |-> (r_s2v && r_s2.has_bord && !r_s2.has_int))
        else $error("non-last result without pending border pixel");

    // Once a first-of-two result is taken, the last one follows at once
    a_partner_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_olast && !i_stall) |=> (r_ov && r_olast))
        else $error("second result did not follow the first");

endmodule

[design/box_blur_3x3_rgb_unit.sv]
// 3x3 box blur over a raster-order RGB pixel stream: top level.
//
// Input channel: one RGB pixel per request (i_valid / o_stall), in raster
// order. Output channel: result pixels with coordinates (o_valid / i_stall).
// Border pixels come out unchanged; each pixel at column >= 2 and row >= 2
// also completes the window of the pixel up-left of it, which comes out as
// the per-channel 3x3 sum divided by 9, ahead of the border pixel when a
// request yields both. o_run_last marks the last result of a request.
// Frame geometry is set through i_cfg_wr_en / i_cfg_index / i_cfg_data; a
// write to frame_width or frame_height restarts the frame at column 0, row 0.
// Throughput: one pixel per cycle while the receiver does not stall; a pixel
// that yields two results holds the divide stage until both have gone out,
// since the single output register takes one result per cycle.
// Reset: position 0,0, geometry 640 x 480, pipeline empty. The line stores
// are not cleared; they are filled by the first two rows of a frame.
// Receiver stall: the output register holds; the two stages in front keep
// filling, then o_stall rises and input requests wait.
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bb3_pkg::CHAN_W-1:0]     i_in_red,
    input  logic [bb3_pkg::CHAN_W-1:0]     i_in_green,
    input  logic [bb3_pkg::CHAN_W-1:0]     i_in_blue,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bb3_pkg::CHAN_W-1:0]     o_out_red,
    output logic [bb3_pkg::CHAN_W-1:0]     o_out_green,
    output logic [bb3_pkg::CHAN_W-1:0]     o_out_blue,
    output logic [bb3_pkg::OX_W-1:0]       o_out_x,
    output logic [bb3_pkg::OY_W-1:0]       o_out_y,
    output logic                           o_run_last
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration and position
    logic [bb3_pkg::COL_W-1:0] r_width;
    logic [bb3_pkg::HGT_W-1:0] r_height;
    logic [bb3_pkg::COL_W-1:0] r_col;
    logic [bb3_pkg::ROW_W-1:0] r_row;

    // Stage 1: accepted pixel with its line-store read
    logic                      r_s1v;
    bb3_pkg::t_pix             r_s1_pix;
    logic [bb3_pkg::COL_W-1:0] r_s1_x;
    logic [bb3_pkg::ROW_W-1:0] r_s1_y;
    logic                      r_s1_int;
    logic                      r_s1_bord;

    logic [bb3_pkg::COL_W-1:0] w_eff;
    logic [bb3_pkg::HGT_W-1:0] h_eff;
    logic [bb3_pkg::COL_W-1:0] cur_x;
    logic [bb3_pkg::ROW_W-1:0] cur_y;
    logic [bb3_pkg::COL_W:0]   x_inc;
    logic [bb3_pkg::HGT_W-1:0] y_inc;
    logic [bb3_pkg::COL_W-1:0] n_col;
    logic [bb3_pkg::ROW_W-1:0] n_row;
    logic                      is_int;
    logic                      is_bord;
    logic                      accept;
    logic                      s1_adv;
    logic                      s2_ready;
    bb3_pkg::t_pix             in_pix;
    bb3_pkg::t_pix             rd_top;
    bb3_pkg::t_pix             rd_mid;
    logic [2*bb3_pkg::PIX_W-1:0] rd_data;
    bb3_pkg::t_sum             win_sum;
    bb3_pkg::t_item            s1_item;

    // Effective geometry: zero acts as one, oversize is clipped
    always_comb begin
        if (r_width == '0) begin
            w_eff = 12'd1;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = bb3_pkg::COL_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = 13'd1;
        end else if (r_height > bb3_pkg::ROW_LIMIT) begin
            h_eff = bb3_pkg::ROW_LIMIT;
        end else begin
            h_eff = r_height;
        end
    end

    // Position of the incoming pixel, its classes and the next position
    always_comb begin
        cur_x   = (r_col >= w_eff) ? '0 : r_col;
        cur_y   = ({1'b0, r_row} >= h_eff) ? '0 : r_row;
        is_int  = (cur_x >= 12'd2) && (cur_y >= 12'd2);
        is_bord = (cur_x == '0) || (cur_y == '0) || (cur_x == w_eff - 12'd1)
               || ({1'b0, cur_y} == h_eff - 13'd1);
        x_inc   = {1'b0, cur_x} + 13'd1;
        y_inc   = {1'b0, cur_y} + 13'd1;
        n_col   = x_inc[bb3_pkg::COL_W-1:0];
        n_row   = cur_y;
        if (x_inc >= {1'b0, w_eff}) begin
            n_col = '0;
            n_row = (y_inc >= h_eff) ? '0 : y_inc[bb3_pkg::ROW_W-1:0];
        end
    end

    // Pipeline handshake
    assign s1_adv  = r_s1v && s2_ready;
    assign o_stall = r_s1v && !s2_ready;
    assign accept  = i_valid && !o_stall;

    // Configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bb3_pkg::WIDTH_RESET;
            r_height <= bb3_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_s1v    <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == bb3_pkg::REG_FRAME_WIDTH)) begin
                r_width <= i_cfg_data[bb3_pkg::COL_W-1:0];
                r_col   <= '0;
                r_row   <= '0;
            end else if (i_cfg_wr_en && (i_cfg_index == bb3_pkg::REG_FRAME_HEIGHT)) begin
                r_height <= i_cfg_data;
                r_col    <= '0;
                r_row    <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (!r_s1v || s2_ready) begin
                r_s1v <= accept;
            end
        end
    end

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= in_pix;
            r_s1_x    <= cur_x;
            r_s1_y    <= cur_y;
            r_s1_int  <= is_int;
            r_s1_bord <= is_bord;
        end
    end

    // Rows above: read at the incoming column, written as the pixel moves on
    bb3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(cur_x)),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (AW'(r_s1_x)),
        .i_wr_data ({rd_mid, r_s1_pix})
    );

    assign rd_top = rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
    assign rd_mid = rd_data[bb3_pkg::PIX_W-1:0];

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_shift (s1_adv),
        .i_top   (rd_top),
        .i_mid   (rd_mid),
        .i_pix   (r_s1_pix),
        .o_sum   (win_sum)
    );

    always_comb begin
        s1_item.sum      = win_sum;
        s1_item.pix      = r_s1_pix;
        s1_item.x        = r_s1_x;
        s1_item.y        = r_s1_y;
        s1_item.has_int  = r_s1_int;
        s1_item.has_bord = r_s1_bord;
    end

    bb3_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1v),
        .i_item      (s1_item),
        .o_ready     (s2_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_run_last  (o_run_last)
    );

    // The position always stays inside the frame after a step
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_wr_en) |=> ((r_col < w_eff) && ({1'b0, r_row} < h_eff)))
        else $error("position left the frame");

    // An interior pixel is never in the first two columns of its row
    a_int_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1v && r_s1_int) |-> (r_s1_x >= 12'd2))
        else $error("interior request at too small a column");

endmodule
